FILE: design/lzd_pkg.sv
// lzd_pkg: constants, types and helpers for the lz stream decompressor
// used by lzd_history_ram and lz_stream_decompressor; no dependencies
`timescale 1ns / 1ps

package lzd_pkg;

   localparam int WINDOW_BYTES = 65536;
   localparam int WIN_BITS = $clog2(WINDOW_BYTES);

   localparam logic [31:0] HDR_MAGIC = 32'h57bC_0000;
   localparam logic [16:0] ADLER_BASE = 17'd65521;
   localparam logic [24:0] WINDOW_LIMIT = 25'(WINDOW_BYTES);

   localparam logic [7:0] OP_REPEAT = 8'h04;
   localparam logic [7:0] OP_END = 8'h05;
   localparam logic [7:0] OP_MATCH_FAR = 8'h06;
   localparam logic [7:0] OP_LIT_LONG = 8'h07;
   localparam logic [7:0] END_TAG = 8'hfa;

   localparam logic [3:0] ST_RUNNING = 4'd0;
   localparam logic [3:0] ST_OK = 4'd1;
   localparam logic [3:0] ST_BAD_HEADER = 4'd2;
   localparam logic [3:0] ST_BAD_OPCODE = 4'd3;
   localparam logic [3:0] ST_OVERFLOW = 4'd4;
   localparam logic [3:0] ST_BEFORE_START = 4'd5;
   localparam logic [3:0] ST_BEYOND_WINDOW = 4'd6;
   localparam logic [3:0] ST_LEN_MISMATCH = 4'd7;
   localparam logic [3:0] ST_CHECKSUM = 4'd8;

   typedef enum logic [6:0] {
      PH_HEADER   = 7'b0000001,
      PH_OPCODE   = 7'b0000010,
      PH_ARGS     = 7'b0000100,
      PH_LITERAL  = 7'b0001000,
      PH_ENDMARK  = 7'b0010000,
      PH_CHECKSUM = 7'b0100000,
      PH_DONE     = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
      logic [7:0]          data;
   } hist_wr_type;

   typedef struct packed {
      logic                en;
      logic [WIN_BITS-1:0] addr;
   } hist_rd_type;

   // argument bytes that follow an opcode
   function automatic logic [2:0] arg_bytes(input logic [7:0] op);
      logic [2:0] n;
      n = 3'd0;
      if (op >= 8'h80) n = 3'd1;
      else if (op >= 8'h40) n = 3'd2;
      else if (op >= 8'h20) n = 3'd0;
      else if (op >= 8'h18) n = 3'd3;
      else if (op >= 8'h10) n = 3'd4;
      else if (op >= 8'h08) n = 3'd1;
      else if (op == OP_LIT_LONG) n = 3'd2;
      else if (op == OP_MATCH_FAR) n = 3'd4;
      else if (op == OP_REPEAT) n = 3'd5;
      else if (op == OP_END) n = 3'd1;
      return n;
   endfunction

endpackage

FILE: design/lzd_history_ram.sv
// lzd_history_ram: window history memory, one write and one registered read port
// depends on lzd_pkg
`timescale 1ns / 1ps

module lzd_history_ram
   import lzd_pkg::*;
(
   input  logic        clock,
   input  hist_wr_type wr,
   input  hist_rd_type rd,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [WINDOW_BYTES];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

FILE: design/lz_stream_decompressor.sv
// lz_stream_decompressor: streaming lz77 decoder with adler-32 trailer check
// depends on lzd_pkg and lzd_history_ram
//
//   channel | direction | handshake           | payload
//   req     | in        | req_valid/req_stall | req_type, req_in_byte
//   rsp     | out       | rsp_valid/rsp_stall | rsp_accepted .. rsp_status
//
// one item per cycle sustained unless rsp_stall holds the pipe; parsing and
// counters settle in the accept cycle, then the stage register, where the
// history read result feeds checksum and write-back, then the output register.
// reset clears all control state; the history memory is never cleared.
// rsp_stall holds the output register and the stage behind it; req_stall
// rises only when that stage is full and cannot drain.
`timescale 1ns / 1ps

module lz_stream_decompressor
   import lzd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_type,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_accepted,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_copy_pending,
   output logic       rsp_done_res,
   output logic [3:0] rsp_status
);

   phase_type   phase_ff, phase_in;
   logic [31:0] field_ff, field_in;
   logic [4:0]  bif_ff, bif_in;
   logic [7:0]  op_ff, op_in;
   logic [31:0] exp_ff, exp_in;
   logic [31:0] prod_ff, prod_in;
   logic [16:0] copy_ff, copy_in;
   logic [24:0] dist_ff, dist_in;
   logic [16:0] lit_ff, lit_in;
   logic [15:0] sl_ff, sl_in;
   logic [15:0] sh_ff, sh_in;
   logic [3:0]  err_ff, err_in;

   logic        in_xfer, advance, move;
   logic        emit_lit, emit_copy;
   logic        fail_en;
   logic [3:0]  fail_val;
   logic        do_lit, do_match;
   logic [16:0] l_len, m_len;
   logic [24:0] m_dist;
   logic [31:0] f;
   logic [4:0]  bif1;
   logic [32:0] end_pos;

   logic                s1_valid_ff, s1_acc_ff, s1_emit_ff, s1_copy_ff;
   logic [7:0]          s1_lit_ff;
   logic [WIN_BITS-1:0] s1_waddr_ff;
   logic                s1_pend_ff, s1_done_ff;
   logic [3:0]          s1_status_ff;
   logic                fwd_hit_ff, fwd_hit_in;
   logic [7:0]          fwd_byte_ff;

   logic        rsp_valid_ff, rsp_acc_ff, rsp_ov_ff, rsp_pend_ff, rsp_done_ff;
   logic [7:0]  rsp_byte_ff;
   logic [3:0]  rsp_status_ff;

   hist_wr_type hwr;
   hist_rd_type hrd;
   logic [7:0]  mem_q;
   logic [7:0]  byte_b;
   logic [16:0] lo1, lo, hi1, hi;
   logic [31:0] src_full;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign req_stall = s1_valid_ff && !advance;
   assign in_xfer = req_valid && !req_stall;
   assign move = s1_valid_ff && advance;

   // parse and control, settled in the transfer cycle
   always_comb begin
      phase_in = phase_ff;
      field_in = field_ff;
      bif_in = bif_ff;
      op_in = op_ff;
      exp_in = exp_ff;
      prod_in = prod_ff;
      copy_in = copy_ff;
      dist_in = dist_ff;
      lit_in = lit_ff;
      err_in = err_ff;
      emit_lit = 1'b0;
      emit_copy = 1'b0;
      fail_en = 1'b0;
      fail_val = ST_RUNNING;
      do_lit = 1'b0;
      do_match = 1'b0;
      l_len = '0;
      m_len = '0;
      m_dist = '0;
      f = {field_ff[23:0], req_in_byte};
      bif1 = bif_ff + 5'd1;
      end_pos = '0;
      if (in_xfer) begin
         if (req_type) begin
            if (copy_ff != '0 && phase_ff != PH_DONE) begin
               emit_copy = 1'b1;
               copy_in = copy_ff - 17'd1;
            end
         end else if (phase_ff != PH_DONE && copy_ff == '0) begin
            case (phase_ff)
               PH_HEADER: begin
                  field_in = f;
                  if (bif_ff == 5'd3 && f != HDR_MAGIC) begin
                     fail_en = 1'b1;
                     fail_val = ST_BAD_HEADER;
                  end else if (bif_ff == 5'd7 && f != '0) begin
                     fail_en = 1'b1;
                     fail_val = ST_BAD_HEADER;
                  end else begin
                     if (bif_ff == 5'd11) exp_in = f;
                     if (bif1 >= 5'd16) begin
                        bif_in = '0;
                        field_in = '0;
                        phase_in = PH_OPCODE;
                     end else begin
                        bif_in = bif1;
                     end
                  end
               end
               PH_OPCODE: begin
                  op_in = req_in_byte;
                  field_in = '0;
                  bif_in = '0;
                  if (req_in_byte inside {[8'h20:8'h3f]}) begin
                     do_lit = 1'b1;
                     l_len = 17'(req_in_byte - 8'h1f);
                  end else if (req_in_byte == OP_END) begin
                     phase_in = PH_ENDMARK;
                  end else if (arg_bytes(req_in_byte) == 3'd0) begin
                     fail_en = 1'b1;
                     fail_val = ST_BAD_OPCODE;
                  end else begin
                     phase_in = PH_ARGS;
                  end
               end
               PH_ARGS: begin
                  field_in = f;
                  bif_in = bif1;
                  if (op_ff == OP_REPEAT && bif1 == 5'd3) begin
                     dist_in = 25'(f[23:0]) + 25'd1;
                     field_in = '0;
                  end
                  if (bif1 >= 5'(arg_bytes(op_ff))) begin
                     bif_in = '0;
                     if (op_ff >= 8'h80) begin
                        do_match = 1'b1;
                        m_dist = 25'(f[7:0]) + 25'd1;
                        m_len = 17'(op_ff - 8'h7f);
                     end else if (op_ff >= 8'h40) begin
                        do_match = 1'b1;
                        m_dist = 25'({op_ff[5:0], f[15:8]}) + 25'd1;
                        m_len = 17'(f[7:0]) + 17'd1;
                     end else if (op_ff inside {[8'h18:8'h1f]}) begin
                        do_match = 1'b1;
                        m_dist = 25'({op_ff[2:0], f[23:8]}) + 25'd1;
                        m_len = 17'(f[7:0]) + 17'd1;
                     end else if (op_ff inside {[8'h10:8'h17]}) begin
                        do_match = 1'b1;
                        m_dist = 25'({op_ff[2:0], f[31:16]}) + 25'd1;
                        m_len = 17'(f[15:0]) + 17'd1;
                     end else if (op_ff inside {[8'h08:8'h0f]}) begin
                        do_lit = 1'b1;
                        l_len = 17'({op_ff[2:0], f[7:0]}) + 17'd1;
                     end else if (op_ff == OP_LIT_LONG) begin
                        do_lit = 1'b1;
                        l_len = 17'(f[15:0]) + 17'd1;
                     end else if (op_ff == OP_MATCH_FAR) begin
                        do_match = 1'b1;
                        m_dist = 25'(f[31:8]) + 25'd1;
                        m_len = 17'(f[7:0]) + 17'd1;
                     end else if (op_ff == OP_REPEAT) begin
                        do_match = 1'b1;
                        m_dist = dist_ff;
                        m_len = 17'(f[15:0]) + 17'd1;
                     end else begin
                        fail_en = 1'b1;
                        fail_val = ST_BAD_OPCODE;
                     end
                  end
               end
               PH_LITERAL: begin
                  emit_lit = 1'b1;
                  lit_in = lit_ff - 17'd1;
                  if (lit_ff == 17'd1) phase_in = PH_OPCODE;
               end
               PH_ENDMARK: begin
                  if (req_in_byte != END_TAG) begin
                     fail_en = 1'b1;
                     fail_val = ST_BAD_OPCODE;
                  end else if (prod_ff != exp_ff) begin
                     fail_en = 1'b1;
                     fail_val = ST_LEN_MISMATCH;
                  end else begin
                     field_in = '0;
                     bif_in = '0;
                     phase_in = PH_CHECKSUM;
                  end
               end
               PH_CHECKSUM: begin
                  field_in = f;
                  bif_in = bif1;
                  if (bif1 >= 5'd4) begin
                     fail_en = 1'b1;
                     fail_val = (f == {sh_ff, sl_ff}) ? ST_OK : ST_CHECKSUM;
                  end
               end
               default: begin
                  fail_en = 1'b1;
                  fail_val = ST_BAD_OPCODE;
               end
            endcase
         end
      end
      if (do_lit) begin
         end_pos = {1'b0, prod_ff} + 33'(l_len);
         if (end_pos > {1'b0, exp_ff}) begin
            fail_en = 1'b1;
            fail_val = ST_OVERFLOW;
         end else begin
            lit_in = l_len;
            phase_in = PH_LITERAL;
         end
      end
      if (do_match) begin
         end_pos = {1'b0, prod_ff} + 33'(m_len);
         if (end_pos > {1'b0, exp_ff}) begin
            fail_en = 1'b1;
            fail_val = ST_OVERFLOW;
         end else if (32'(m_dist) > prod_ff) begin
            fail_en = 1'b1;
            fail_val = ST_BEFORE_START;
         end else if (m_dist > WINDOW_LIMIT) begin
            fail_en = 1'b1;
            fail_val = ST_BEYOND_WINDOW;
         end else begin
            dist_in = m_dist;
            copy_in = m_len;
            phase_in = PH_OPCODE;
         end
      end
      if (fail_en) begin
         err_in = fail_val;
         phase_in = PH_DONE;
         copy_in = '0;
         lit_in = '0;
      end
      if (emit_lit || emit_copy) prod_in = prod_ff + 32'd1;
   end

   // history read for copies, with bypass of the write landing in the same cycle
   assign src_full = prod_ff - 32'(dist_ff);
   assign hrd.en = in_xfer;
   assign hrd.addr = src_full[WIN_BITS-1:0];

   assign byte_b = s1_copy_ff ? (fwd_hit_ff ? fwd_byte_ff : mem_q) : s1_lit_ff;
   assign hwr.en = move && s1_emit_ff;
   assign hwr.addr = s1_waddr_ff;
   assign hwr.data = byte_b;
   assign fwd_hit_in = hwr.en && (hwr.addr == hrd.addr);

   lzd_history_ram u_hist (
      .clock   (clock),
      .wr      (hwr),
      .rd      (hrd),
      .rd_data (mem_q)
   );

   // adler-32 update
   always_comb begin
      lo1 = 17'(sl_ff) + 17'(byte_b);
      lo = (lo1 >= ADLER_BASE) ? lo1 - ADLER_BASE : lo1;
      hi1 = 17'(sh_ff) + lo;
      hi = (hi1 >= ADLER_BASE) ? hi1 - ADLER_BASE : hi1;
      sl_in = sl_ff;
      sh_in = sh_ff;
      if (hwr.en) begin
         sl_in = lo[15:0];
         sh_in = hi[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HEADER;
         field_ff <= '0;
         bif_ff <= '0;
         op_ff <= '0;
         exp_ff <= '0;
         prod_ff <= '0;
         copy_ff <= '0;
         dist_ff <= '0;
         lit_ff <= '0;
         sl_ff <= 16'd1;
         sh_ff <= '0;
         err_ff <= ST_RUNNING;
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         field_ff <= field_in;
         bif_ff <= bif_in;
         op_ff <= op_in;
         exp_ff <= exp_in;
         prod_ff <= prod_in;
         copy_ff <= copy_in;
         dist_ff <= dist_in;
         lit_ff <= lit_in;
         sl_ff <= sl_in;
         sh_ff <= sh_in;
         err_ff <= err_in;
         if (in_xfer) s1_valid_ff <= 1'b1;
         else if (advance) s1_valid_ff <= 1'b0;
         if (advance) rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_xfer) begin
         s1_acc_ff <= !req_type && phase_ff != PH_DONE && copy_ff == '0;
         s1_emit_ff <= emit_lit || emit_copy;
         s1_copy_ff <= emit_copy;
         s1_lit_ff <= req_in_byte;
         s1_waddr_ff <= prod_ff[WIN_BITS-1:0];
         s1_pend_ff <= copy_in != '0 && phase_in != PH_DONE;
         s1_done_ff <= phase_in == PH_DONE;
         s1_status_ff <= err_in;
         fwd_hit_ff <= fwd_hit_in;
         fwd_byte_ff <= hwr.data;
      end
      if (move) begin
         rsp_acc_ff <= s1_acc_ff;
         rsp_ov_ff <= s1_emit_ff;
         rsp_byte_ff <= s1_emit_ff ? byte_b : 8'd0;
         rsp_pend_ff <= s1_pend_ff;
         rsp_done_ff <= s1_done_ff;
         rsp_status_ff <= s1_status_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_acc_ff;
   assign rsp_out_valid = rsp_ov_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_copy_pending = rsp_pend_ff;
   assign rsp_done_res = rsp_done_ff;
   assign rsp_status = rsp_status_ff;

endmodule
